### src/pfde_pkg.sv
// Shared constants, types and helpers of the page framebuffer draw engine.
package pfde_pkg;

	localparam int SCREEN_W    = 128;
	localparam int SCREEN_H    = 64;
	localparam int PAGE_ROWS   = 8;
	localparam int PAGE_COUNT  = (SCREEN_H + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int STORE_BYTES = SCREEN_W * PAGE_COUNT;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int COORD_W     = 8;
	localparam int BYTE_W      = 8;

	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

	typedef enum logic [1:0] {
		ACT_PIXEL = 2'd0,
		ACT_RECT  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_RD_DONE
	} state_t;

	typedef struct packed {
		action_t              action;
		logic [COORD_W-1:0]   x_start;
		logic [COORD_W-1:0]   y_start;
		logic [COORD_W-1:0]   x_end;
		logic [COORD_W-1:0]   y_end;
		logic                 pixel_on;
		logic                 fill_inside;
		logic [2:0]           page_index;
		logic [6:0]           column_index;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
		logic               fill;
		logic               on;
	} geom_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [BYTE_W-1:0] mask;
		logic              on;
		logic              zero;
	} mem_req_t;

	typedef struct packed {
		logic in_ready;
		logic load_out;
		logic rd_zero;
	} seq_stat_t;

	function automatic logic [ADDR_W-1:0] byte_addr(input logic [COORD_W-1:0] col,
			input logic [PAGE_W-1:0] page);
		return ADDR_W'(32'(page) * SCREEN_W + 32'(col));
	endfunction

endpackage

### src/page_framebuffer_draw_engine_core.sv
// Top level of the page framebuffer draw engine: handshakes and result register.
// Pixel write: a read then a merged write of one store byte, none if off-screen.
// Page byte read: the result sits in an output register; a new beat is taken only once it is loaded.
// Rectangle: a read and a merged write per page byte inside the clipped bounding box, none if fully off-screen.
// Clear: one store byte written per cycle through the write port.
// After arst_n release a clearing pass zeroes the store; input is not ready until it ends.
module page_framebuffer_draw_engine_core
	import pfde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  logic [7:0]        x_start,
	input  logic [7:0]        y_start,
	input  logic [7:0]        x_end,
	input  logic [7:0]        y_end,
	input  logic              pixel_on,
	input  logic              fill_inside,
	input  logic [2:0]        page_index,
	input  logic [6:0]        column_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        page_byte
);

	item_t             item;
	mem_req_t          req;
	seq_stat_t         stat;
	logic [BYTE_W-1:0] rd_data;
	logic              out_valid_q;
	logic [BYTE_W-1:0] page_byte_q;
	logic              out_free;

	// pack the input beat
	always_comb begin
		item.action       = action_t'(action);
		item.x_start      = x_start;
		item.y_start      = y_start;
		item.x_end        = x_end;
		item.y_end        = y_end;
		item.pixel_on     = pixel_on;
		item.fill_inside  = fill_inside;
		item.page_index   = page_index;
		item.column_index = column_index;
	end

	// output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;

	pfde_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item     (item),
		.out_free (out_free),
		.req      (req),
		.stat     (stat)
	);

	pfde_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	// result register: holds a read beat until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// an out-of-range read returns zero
	always_ff @(posedge clk) begin
		if (stat.load_out) begin
			page_byte_q <= stat.rd_zero ? '0 : rd_data;
		end
	end

	assign in_ready  = stat.in_ready;
	assign out_valid = out_valid_q;
	assign page_byte = page_byte_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.load_out |-> out_free)
		else $error("result register overwritten");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stat.load_out && stat.rd_zero |=> page_byte_q == '0)
		else $error("out-of-range read not zero");

endmodule

### src/pfde_mask.sv
// Row mask unit: which pixels of one page byte a rectangle paints.
module pfde_mask
	import pfde_pkg::*;
(
	input  geom_t              geom,
	input  logic [COORD_W-1:0] col,
	input  logic [PAGE_W-1:0]  page,
	output logic [BYTE_W-1:0]  mask
);

	logic [8:0] row_y [PAGE_ROWS];
	logic [8:0] x, x1, x2, y1, y2;
	logic       in_xr, on_xe, in_xf;

	assign x  = {1'b0, col};
	assign x1 = {1'b0, geom.x1};
	assign x2 = {1'b0, geom.x2};
	assign y1 = {1'b0, geom.y1};
	assign y2 = {1'b0, geom.y2};

	assign in_xr = (x >= x1) && (x <= x2);
	assign on_xe = (x == x1) || (x == x2);
	assign in_xf = geom.fill && (x >= x1) && (x < x2);

	always_comb begin
		for (int b = 0; b < PAGE_ROWS; b++) begin
			row_y[b] = 9'({page, 3'(b)});
			mask[b]  = (row_y[b] < 9'(SCREEN_H)) && (
				(in_xr && ((row_y[b] == y1) || (row_y[b] == y2))) ||
				(on_xe && (row_y[b] >= y1) && (row_y[b] <= y2)) ||
				(in_xf && (row_y[b] >= y1) && (row_y[b] < y2)));
		end
	end

endmodule

### src/pfde_store.sv
// Frame store memory with registered read and read-modify-write merge.
module pfde_store
	import pfde_pkg::*;
(
	input  logic              clk,
	input  mem_req_t          req,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [STORE_BYTES];
	logic [BYTE_W-1:0] rd_data_q;
	logic [BYTE_W-1:0] wr_data;

	always_comb begin
		if (req.zero) begin
			wr_data = '0;
		end else if (req.on) begin
			wr_data = rd_data_q | req.mask;
		end else begin
			wr_data = rd_data_q & (BYTE_ONES ^ req.mask);
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/pfde_seq.sv
// Sequencer: byte walk over a clipped rectangle, clear sweep and read control.
module pfde_seq
	import pfde_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  item_t     item,
	input  logic      out_free,
	output mem_req_t  req,
	output seq_stat_t stat
);

	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_BYTES - 1);

	state_t             state_q, state_d;
	logic [ADDR_W-1:0]  clr_q;
	geom_t              geom_q, geom_d;
	logic [COORD_W-1:0] col_q, col_lo_q, col_hi_q;
	logic [PAGE_W-1:0]  page_q, page_hi_q;
	logic               rd_zero_q;

	// walk bounds taken from the incoming item
	logic [COORD_W-1:0] col_lo, col_max, col_hi, row_lo, row_max, row_hi;
	logic [PAGE_W-1:0]  page_lo, page_hi;
	logic               walk_empty, rd_in_range, last_byte;
	logic [ADDR_W-1:0]  cur_addr;
	logic [BYTE_W-1:0]  mask;

	always_comb begin
		geom_d.x1   = item.x_start;
		geom_d.y1   = item.y_start;
		geom_d.x2   = (item.action == ACT_PIXEL) ? item.x_start : item.x_end;
		geom_d.y2   = (item.action == ACT_PIXEL) ? item.y_start : item.y_end;
		geom_d.fill = (item.action == ACT_RECT) && item.fill_inside;
		geom_d.on   = item.pixel_on;
	end

	assign col_lo  = (geom_d.x1 < geom_d.x2) ? geom_d.x1 : geom_d.x2;
	assign col_max = (geom_d.x1 < geom_d.x2) ? geom_d.x2 : geom_d.x1;
	assign row_lo  = (geom_d.y1 < geom_d.y2) ? geom_d.y1 : geom_d.y2;
	assign row_max = (geom_d.y1 < geom_d.y2) ? geom_d.y2 : geom_d.y1;
	assign col_hi  = ({1'b0, col_max} >= 9'(SCREEN_W)) ? COORD_W'(SCREEN_W - 1) : col_max;
	assign row_hi  = ({1'b0, row_max} >= 9'(SCREEN_H)) ? COORD_W'(SCREEN_H - 1) : row_max;
	assign page_lo = PAGE_W'(row_lo >> 3);
	assign page_hi = PAGE_W'(row_hi >> 3);
	assign walk_empty = ({1'b0, col_lo} >= 9'(SCREEN_W)) || ({1'b0, row_lo} >= 9'(SCREEN_H));

	assign rd_in_range = (32'(item.page_index) < PAGE_COUNT) &&
		(32'(item.column_index) < SCREEN_W);

	assign last_byte = (col_q == col_hi_q) && (page_q == page_hi_q);
	assign cur_addr  = byte_addr(col_q, page_q);

	pfde_mask u_mask (
		.geom (geom_q),
		.col  (col_q),
		.page (page_q),
		.mask (mask)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (item.action)
						ACT_READ:  state_d = ST_RD_DONE;
						ACT_CLEAR: state_d = ST_CLEAR;
						default:   state_d = walk_empty ? ST_IDLE : ST_WRITE;
					endcase
				end
			end
			ST_READ:    state_d = ST_WRITE;
			ST_WRITE:   state_d = last_byte ? ST_IDLE : ST_READ;
			ST_RD_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req  = '0;
		stat = '0;
		unique case (state_q)
			ST_CLEAR: begin
				req.wr_en   = 1'b1;
				req.wr_addr = clr_q;
				req.zero    = 1'b1;
			end
			ST_IDLE: begin
				stat.in_ready = 1'b1;
				if (in_valid) begin
					unique case (item.action)
						ACT_READ: begin
							req.rd_en   = 1'b1;
							req.rd_addr = ADDR_W'(32'(item.page_index) * SCREEN_W +
								32'(item.column_index));
						end
						ACT_CLEAR: begin
							req.rd_en = 1'b0;
						end
						default: begin
							req.rd_en   = !walk_empty;
							req.rd_addr = byte_addr(col_lo, page_lo);
						end
					endcase
				end
			end
			ST_READ: begin
				req.rd_en   = 1'b1;
				req.rd_addr = cur_addr;
			end
			ST_WRITE: begin
				req.wr_en   = 1'b1;
				req.wr_addr = cur_addr;
				req.mask    = mask;
				req.on      = geom_q.on;
			end
			ST_RD_DONE: begin
				stat.load_out = out_free;
				stat.rd_zero  = rd_zero_q;
			end
			default: begin
				stat.in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end else begin
				clr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			geom_q    <= geom_d;
			col_q     <= col_lo;
			col_lo_q  <= col_lo;
			col_hi_q  <= col_hi;
			page_q    <= page_lo;
			page_hi_q <= page_hi;
			rd_zero_q <= !rd_in_range;
		end else if (state_q == ST_WRITE && !last_byte) begin
			if (col_q == col_hi_q) begin
				col_q  <= col_lo_q;
				page_q <= page_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	a_walk_col: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> col_q >= col_lo_q && col_q <= col_hi_q)
		else $error("walk column left its range");

	a_walk_page: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> page_q <= page_hi_q)
		else $error("walk page past last page");

	a_wr_addr: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> 32'(req.wr_addr) < STORE_BYTES)
		else $error("write beyond frame store");

	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> $past(req.rd_en))
		else $error("merge write without preceding read");

endmodule

### tb/page_framebuffer_draw_engine_core_tb.sv
// Self-checking testbench for the page framebuffer draw engine: pixels, boxes, clears, reads.
module page_framebuffer_draw_engine_core_tb;
	import pfde_pkg::*;

	// quiet-cycle watchdog: a full-screen box, the power-up clearing pass and the long
	// result hold-off all end well inside it, so this is several times the worst case
	localparam int QUIET_LIMIT  = 20000;
	// settle time after the last beat: covers the slowest box still being drawn
	localparam int SETTLE_WAIT  = 2100;
	localparam int HOLD_OFF_LEN = 400;
	localparam int RANDOM_BEATS = 1850;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [7:0]  x_start;
	logic [7:0]  y_start;
	logic [7:0]  x_end;
	logic [7:0]  y_end;
	logic        pixel_on;
	logic        fill_inside;
	logic [2:0]  page_index;
	logic [6:0]  column_index;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  page_byte;

	// shadow copy of the display memory, one byte per column per 8-row page
	logic [7:0]  fb_image [STORE_BYTES];
	// page bytes that reads have asked for, oldest first
	logic [7:0]  pending_bytes [$];

	int          err_count;
	int          quiet_cycles;
	int          rx_hold_req;
	bit          tx_idle_on;
	bit          rx_idle_on;
	logic [7:0]  want_byte;

	page_framebuffer_draw_engine_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.pixel_on    (pixel_on),
		.fill_inside (fill_inside),
		.page_index  (page_index),
		.column_index(column_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.page_byte   (page_byte)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Framebuffer predictor
	// ------------------------------------------------------------------

	// Off-screen pixels are dropped here, which is what clips every drawing.
	function automatic void paint_pixel(input int x, input int y, input bit on);
		int addr;
		if (x >= SCREEN_W || y >= SCREEN_H)
			return;
		addr = x + (y / 8) * SCREEN_W;
		fb_image[addr][y % 8] = on;
	endfunction

	// Outline edges first, then the optional interior. Edge walks stop at the
	// screen border; reversed edges leave the matching walk empty.
	function automatic void paint_rect(input int x1, input int y1, input int x2, input int y2,
			input bit on, input bit fill);
		int xe;
		int ye;
		xe = (x2 < SCREEN_W) ? x2 : SCREEN_W - 1;
		for (int x = x1; x <= xe && x <= x2; x++) begin
			paint_pixel(x, y1, on);
			paint_pixel(x, y2, on);
		end
		ye = (y2 < SCREEN_H) ? y2 : SCREEN_H - 1;
		for (int y = y1; y <= ye && y <= y2; y++) begin
			paint_pixel(x1, y, on);
			paint_pixel(x2, y, on);
		end
		if (fill) begin
			for (int x = x1; x < x2 && x < SCREEN_W; x++)
				for (int y = y1; y < y2 && y < SCREEN_H; y++)
					paint_pixel(x, y, on);
		end
	endfunction

	// Update the shadow image for one accepted beat; reads queue their byte.
	function automatic void apply_beat(input item_t it);
		logic [7:0] val;
		case (it.action)
			ACT_PIXEL: paint_pixel(int'(it.x_start), int'(it.y_start), it.pixel_on);
			ACT_RECT:  paint_rect(int'(it.x_start), int'(it.y_start), int'(it.x_end),
					int'(it.y_end), it.pixel_on, it.fill_inside);
			ACT_CLEAR: begin
				foreach (fb_image[i])
					fb_image[i] = 8'h00;
			end
			default: begin
				val = 8'h00;
				if (it.page_index < PAGE_COUNT && it.column_index < SCREEN_W)
					val = fb_image[int'(it.column_index) + int'(it.page_index) * SCREEN_W];
				pending_bytes.push_back(val);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// idle length: mostly none, sometimes a few cycles, rarely a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// every field random, so each action sees noise on the fields it ignores
	function automatic item_t noise_item(input action_t act);
		item_t it;
		it.action       = act;
		it.x_start      = 8'($urandom);
		it.y_start      = 8'($urandom);
		it.x_end        = 8'($urandom);
		it.y_end        = 8'($urandom);
		it.pixel_on     = 1'($urandom);
		it.fill_inside  = 1'($urandom);
		it.page_index   = 3'($urandom);
		it.column_index = 7'($urandom);
		return it;
	endfunction

	task automatic fault(input string what, input logic [7:0] want, input logic [7:0] got);
		err_count++;
		if (err_count <= 10)
			$display("ERROR %s: expected page_byte %02h, got %02h at %0t", what, want, got, $time);
	endtask

	// Offer one beat, hold it until accepted, then update the predictor.
	// in_valid is left high on return; settle_results or an idle gap in the next send drops it.
	task automatic send_beat(input item_t it);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= it.action;
		x_start      <= it.x_start;
		y_start      <= it.y_start;
		x_end        <= it.x_end;
		y_end        <= it.y_end;
		pixel_on     <= it.pixel_on;
		fill_inside  <= it.fill_inside;
		page_index   <= it.page_index;
		column_index <= it.column_index;
		do @(posedge clk); while (in_ready !== 1'b1);
		apply_beat(it);
	endtask

	// stop offering and wait until every requested byte has come back;
	// in_valid stays low for the whole wait
	task automatic settle_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	task automatic draw_pixel(input int x, input int y, input bit on);
		item_t it;
		it = noise_item(ACT_PIXEL);
		it.x_start  = 8'(x);
		it.y_start  = 8'(y);
		it.pixel_on = on;
		send_beat(it);
	endtask

	task automatic draw_box(input int x1, input int y1, input int x2, input int y2,
			input bit on, input bit fill);
		item_t it;
		it = noise_item(ACT_RECT);
		it.x_start     = 8'(x1);
		it.y_start     = 8'(y1);
		it.x_end       = 8'(x2);
		it.y_end       = 8'(y2);
		it.pixel_on    = on;
		it.fill_inside = fill;
		send_beat(it);
	endtask

	task automatic read_byte(input int page, input int col);
		item_t it;
		it = noise_item(ACT_READ);
		it.page_index   = 3'(page);
		it.column_index = 7'(col);
		send_beat(it);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// corner pixels, off-screen pixels (column, row, both at max), erase
	task automatic test_pixel_edges();
		draw_pixel(0, 0, 1'b1);
		draw_pixel(SCREEN_W - 1, SCREEN_H - 1, 1'b1);
		draw_pixel(SCREEN_W, 5, 1'b1);
		draw_pixel(5, SCREEN_H, 1'b1);
		draw_pixel(255, 255, 1'b1);
		read_byte(0, 0);
		read_byte(PAGE_COUNT - 1, SCREEN_W - 1);
		draw_pixel(0, 0, 1'b0);
		read_byte(0, 0);
		read_byte(0, 5);
	endtask

	// outline, filled, reversed edges, a box running past the border and a full-screen erase
	task automatic test_box_shapes();
		draw_box(2, 3, 9, 12, 1'b1, 1'b0);
		read_byte(0, 2);
		read_byte(1, 5);
		draw_box(20, 8, 23, 15, 1'b1, 1'b1);
		read_byte(1, 21);
		draw_box(40, 20, 35, 10, 1'b1, 1'b1);
		read_byte(2, 40);
		draw_box(120, 56, 255, 255, 1'b1, 1'b1);
		read_byte(PAGE_COUNT - 1, SCREEN_W - 1);
		draw_box(0, 0, 255, 255, 1'b0, 1'b1);
		read_byte(1, 21);
	endtask

	// clear must zero every byte; reads check the first one and the byte of a set pixel
	task automatic test_clear_all();
		draw_pixel(0, 0, 1'b1);
		draw_pixel(64, 30, 1'b1);
		send_beat(noise_item(ACT_CLEAR));
		read_byte(0, 0);
		read_byte(3, 64);
		settle_results();
	endtask

	// Hold the result side off for a long stretch while reads keep coming:
	// the output register fills and the block has to stall its input.
	task automatic test_result_hold_off();
		bit saved_tx;
		saved_tx = tx_idle_on;
		tx_idle_on = 1'b0;
		draw_box(10, 10, 30, 40, 1'b1, 1'b1);
		settle_results();
		rx_hold_req = HOLD_OFF_LEN;
		for (int i = 0; i < 12; i++)
			read_byte($urandom_range(1, 5), $urandom_range(8, 32));
		settle_results();
		tx_idle_on = saved_tx;
	endtask

	// Mostly draw-then-read-back sequences around the last drawn spot, plus
	// off-screen coordinates, reversed and rare full-range boxes, and clears.
	task automatic test_random_mix();
		item_t it;
		int    r;
		int    last_x;
		int    last_y;
		int    d;
		last_x = 0;
		last_y = 0;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 150 == 0) begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			r = $urandom_range(0, 99);
			if (r < 35) begin
				it = noise_item(ACT_PIXEL);
				it.pixel_on = ($urandom_range(0, 9) < 7);
				if ($urandom_range(0, 99) < 85) begin
					it.x_start = 8'($urandom_range(0, SCREEN_W - 1));
					it.y_start = 8'($urandom_range(0, SCREEN_H - 1));
				end
			end else if (r < 60) begin
				it = noise_item(ACT_RECT);
				it.pixel_on = ($urandom_range(0, 9) < 7);
				// full-range boxes are slow, so keep them rare
				if ($urandom_range(0, 99) >= 4) begin
					it.x_start = 8'($urandom_range(0, SCREEN_W + 8));
					it.y_start = 8'($urandom_range(0, SCREEN_H + 6));
					if ($urandom_range(0, 9) == 0) begin
						d = int'(it.x_start) - int'($urandom_range(1, 8));
						it.x_end = 8'((d < 0) ? 0 : d);
						d = int'(it.y_start) - int'($urandom_range(0, 8));
						it.y_end = 8'((d < 0) ? 0 : d);
					end else begin
						d = int'(it.x_start) + int'($urandom_range(0, 12));
						it.x_end = 8'((d > 255) ? 255 : d);
						d = int'(it.y_start) + int'($urandom_range(0, 10));
						it.y_end = 8'((d > 255) ? 255 : d);
					end
				end
			end else if (r < 62) begin
				it = noise_item(ACT_CLEAR);
			end else begin
				it = noise_item(ACT_READ);
				if ($urandom_range(0, 9) < 6 && last_y < SCREEN_H) begin
					it.page_index   = 3'(last_y / 8);
					it.column_index = 7'(last_x + int'($urandom_range(0, 4)) - 2);
				end
			end
			if (it.action == ACT_PIXEL || it.action == ACT_RECT) begin
				last_x = int'(it.x_start);
				last_y = int'(it.y_start);
			end
			send_beat(it);
			if ($urandom_range(0, 99) == 0)
				settle_results();
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure plus the requested long hold-off
	// ------------------------------------------------------------------
	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				stall = rx_hold_req;
				rx_hold_req = 0;
			end else begin
				stall = rx_idle_on ? pick_gap() : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// every result beat is matched against the oldest outstanding read
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_bytes.size() == 0) begin
				fault("unexpected result", 8'h00, page_byte);
			end else begin
				want_byte = pending_bytes.pop_front();
				if (page_byte !== want_byte)
					fault("page_byte mismatch", want_byte, page_byte);
			end
		end
	end

	// watchdog: cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_PIXEL;
		x_start      = 8'h00;
		y_start      = 8'h00;
		x_end        = 8'h00;
		y_end        = 8'h00;
		pixel_on     = 1'b0;
		fill_inside  = 1'b0;
		page_index   = 3'd0;
		column_index = 7'd0;
		err_count    = 0;
		quiet_cycles = 0;
		rx_hold_req  = 0;
		tx_idle_on   = 1'b1;
		rx_idle_on   = 1'b1;
		foreach (fb_image[i])
			fb_image[i] = 8'h00;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// the power-up clearing pass keeps in_ready low; send_beat just waits it out
		test_pixel_edges();
		test_box_shapes();
		test_clear_all();
		test_result_hold_off();
		test_random_mix();
		settle_results();
		repeat (SETTLE_WAIT) @(posedge clk);

		while (pending_bytes.size() != 0)
			fault("missing result", pending_bytes.pop_front(), 8'h00);

		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("mismatches: %0d", err_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule
